FILE: hdl/stt_pkg.sv
`default_nettype none
package stt_pkg;

	localparam int INDEX_BITS = 16;
	localparam int SLOT_COUNT = 1 << INDEX_BITS;

	localparam int VERIFY_BITS = 32;
	localparam int MOVE_BITS   = 32;
	localparam int SCORE_BITS  = 16;
	localparam int DEPTH_BITS  = 8;
	localparam int PLY_BITS    = 6;
	localparam int KIND_BITS   = 2;
	localparam int GEN_BITS    = 6;

	// mate window edge: 29000 - 64
	localparam int MATE_VALUE = 29000;
	localparam int PLY_LIMIT  = 64;
	localparam logic signed [SCORE_BITS-1:0] MATE_WIN  = SCORE_BITS'(MATE_VALUE - PLY_LIMIT);
	localparam logic signed [SCORE_BITS-1:0] MATE_LOSS = SCORE_BITS'(-MATE_VALUE + PLY_LIMIT);

	localparam logic OP_PROBE = 1'b0;
	localparam logic OP_STORE = 1'b1;

	localparam logic [KIND_BITS-1:0] KIND_EXACT = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_LOWER = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_UPPER = 2'd2;

	// queue between front and back
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
	localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic                    opcode;
		logic [INDEX_BITS-1:0]   slot;
		logic [VERIFY_BITS-1:0]  verify;
		logic [DEPTH_BITS-1:0]   depth;
		logic [PLY_BITS-1:0]     ply;
		logic [SCORE_BITS-1:0]   alpha;
		logic [SCORE_BITS-1:0]   beta;
		logic [SCORE_BITS-1:0]   score;
		logic [KIND_BITS-1:0]    kind;
		logic [MOVE_BITS-1:0]    move;
	} stt_item_t;

	typedef struct packed {
		logic                    valid;
		logic [VERIFY_BITS-1:0]  verify;
		logic [MOVE_BITS-1:0]    move;
		logic [SCORE_BITS-1:0]   score;
		logic [DEPTH_BITS-1:0]   depth;
		logic [KIND_BITS-1:0]    kind;
		logic [GEN_BITS-1:0]     gen;
	} stt_entry_t;

	localparam int ENTRY_BITS = $bits(stt_entry_t);

endpackage
`default_nettype wire

FILE: hdl/stt_ram.sv
`default_nettype none
module stt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: hdl/stt_front.sv
`default_nettype none
module stt_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire stt_pkg::stt_item_t req,
	input  wire logic              clear_done,
	output      logic              q_valid,
	output      stt_pkg::stt_item_t q_item,
	input  wire logic              q_pop
);

	import stt_pkg::*;

	stt_item_t               buf_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0]   wr_ptr_q;
	logic [Q_PTR_BITS-1:0]   rd_ptr_q;
	logic [Q_CNT_BITS-1:0]   cnt_q;
	logic                    push;
	logic                    pop;
	logic [SCORE_BITS-1:0]   adj_score;
	stt_item_t               item;

	assign in_ready = clear_done && (cnt_q != Q_CNT_BITS'(Q_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = buf_q[rd_ptr_q];

	// push mate scores away from zero by the ply before storing; wraps to 16 bits
	always_comb begin
		adj_score = req.score;
		if ($signed(req.score) > MATE_WIN) begin
			adj_score = req.score + SCORE_BITS'(req.ply);
		end else if ($signed(req.score) < MATE_LOSS) begin
			adj_score = req.score - SCORE_BITS'(req.ply);
		end
		item       = req;
		item.score = (req.opcode == OP_STORE) ? adj_score : req.score;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/stt_back.sv
`default_nettype none
module stt_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [stt_pkg::GEN_BITS-1:0]      cfg_wr_data,
	input  wire logic                              q_valid,
	input  wire stt_pkg::stt_item_t                q_item,
	output      logic                              q_pop,
	output      logic                              clear_done,
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic                              entry_found,
	output      logic                              cutoff_usable,
	output      logic signed [stt_pkg::SCORE_BITS-1:0] score_out,
	output      logic [stt_pkg::MOVE_BITS-1:0]     move_out,
	output      logic                              store_written
);

	import stt_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_EVAL  = 2'd2;

	logic [1:0]              state_q;
	logic [INDEX_BITS-1:0]   clr_addr_q;
	logic [GEN_BITS-1:0]     gen_q;
	stt_item_t               item_q;

	logic                    ram_we;
	logic [INDEX_BITS-1:0]   ram_waddr;
	logic [ENTRY_BITS-1:0]   ram_wdata;
	logic                    ram_re;
	logic [ENTRY_BITS-1:0]   ram_rdata;
	stt_entry_t              rd;
	stt_entry_t              wr_entry;

	logic                    out_valid_q;
	logic                    found_q;
	logic                    cut_q;
	logic [SCORE_BITS-1:0]   score_q;
	logic [MOVE_BITS-1:0]    move_q;
	logic                    written_q;

	logic                    out_free;
	logic                    eval_fire;
	logic                    hit;
	logic                    deep;
	logic [SCORE_BITS-1:0]   s_adj;
	logic                    cut;
	logic [GEN_BITS-1:0]     age;
	logic [DEPTH_BITS:0]     reach;
	logic                    replace;

	stt_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(SLOT_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(q_item.slot),
		.rdata(ram_rdata)
	);

	assign rd         = stt_entry_t'(ram_rdata);
	assign clear_done = (state_q != ST_CLEAR);
	assign out_free   = !out_valid_q || out_ready;
	assign eval_fire  = (state_q == ST_EVAL) && out_free;
	assign q_pop      = (state_q == ST_READ) && q_valid;
	assign ram_re     = q_pop;

	// probe: undo the store-side mate shift, then test the bound
	always_comb begin
		hit   = rd.valid && (rd.verify == item_q.verify);
		deep  = (rd.depth >= item_q.depth);
		s_adj = rd.score;
		if ($signed(rd.score) > MATE_WIN) begin
			s_adj = rd.score - SCORE_BITS'(item_q.ply);
		end else if ($signed(rd.score) < MATE_LOSS) begin
			s_adj = rd.score + SCORE_BITS'(item_q.ply);
		end
		case (rd.kind)
			KIND_EXACT: cut = 1'b1;
			KIND_LOWER: cut = ($signed(s_adj) >= $signed(item_q.beta));
			KIND_UPPER: cut = ($signed(s_adj) <= $signed(item_q.alpha));
			default:    cut = 1'b0;
		endcase
	end

	// store: replace if empty, same position, or old depth <= new depth + 2*age
	always_comb begin
		age     = gen_q - rd.gen;
		reach   = {1'b0, item_q.depth} + (DEPTH_BITS + 1)'({age, 1'b0});
		replace = !rd.valid || (rd.verify == item_q.verify) ||
			(reach >= {1'b0, rd.depth});
		wr_entry.valid  = 1'b1;
		wr_entry.verify = item_q.verify;
		wr_entry.move   = item_q.move;
		wr_entry.score  = item_q.score;
		wr_entry.depth  = item_q.depth;
		wr_entry.kind   = item_q.kind;
		wr_entry.gen    = gen_q;
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = eval_fire && (item_q.opcode == OP_STORE) && replace;
			ram_waddr = item_q.slot;
			ram_wdata = ENTRY_BITS'(wr_entry);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (eval_fire) begin
			if (item_q.opcode == OP_PROBE) begin
				found_q   <= hit;
				cut_q     <= hit && deep && cut;
				score_q   <= (hit && deep) ? s_adj : '0;
				move_q    <= hit ? rd.move : '0;
				written_q <= 1'b0;
			end else begin
				found_q   <= 1'b0;
				cut_q     <= 1'b0;
				score_q   <= '0;
				move_q    <= '0;
				written_q <= replace;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			gen_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				gen_q <= cfg_wr_data;
			end
			if (eval_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == '1) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (q_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					// hold the read data until the output register frees up
					if (out_free) begin
						state_q <= ST_READ;
					end
				end
				default: state_q <= ST_READ;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign entry_found   = found_q;
	assign cutoff_usable = cut_q;
	assign score_out     = score_q;
	assign move_out      = move_q;
	assign store_written = written_q;

endmodule
`default_nettype wire

FILE: hdl/search_transposition_table.sv
`default_nettype none
// channel   | signals                                   | beat when
// ----------+-------------------------------------------+----------------------------
// request   | in_valid/in_ready, opcode .. move_in      | in_valid && in_ready
// result    | out_valid/out_ready, entry_found .. store_written | out_valid && out_ready
// config    | cfg_wr_en, cfg_wr_data (generation)       | cfg_wr_en
//
// In the table engine each request reads its slot in ST_READ, then ST_EVAL evaluates it
// and writes back through the single RAM write port once the result register is free.
// After reset every slot is cleared, one per cycle, all 2^INDEX_BITS (65536) of them;
// in_ready stays low until that is done, config writes are taken throughout.
// A two-beat queue and the result register let either side stall without loss.
module search_transposition_table (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [stt_pkg::GEN_BITS-1:0]      cfg_wr_data,
	input  wire logic                              in_valid,
	output      logic                              in_ready,
	input  wire logic                              opcode,
	input  wire logic [63:0]                       position_hash,
	input  wire logic [stt_pkg::DEPTH_BITS-1:0]    search_depth,
	input  wire logic [stt_pkg::PLY_BITS-1:0]      ply_from_root,
	input  wire logic signed [stt_pkg::SCORE_BITS-1:0] alpha_bound,
	input  wire logic signed [stt_pkg::SCORE_BITS-1:0] beta_bound,
	input  wire logic signed [stt_pkg::SCORE_BITS-1:0] score_in,
	input  wire logic [stt_pkg::KIND_BITS-1:0]     bound_kind,
	input  wire logic [stt_pkg::MOVE_BITS-1:0]     move_in,
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic                              entry_found,
	output      logic                              cutoff_usable,
	output      logic signed [stt_pkg::SCORE_BITS-1:0] score_out,
	output      logic [stt_pkg::MOVE_BITS-1:0]     move_out,
	output      logic                              store_written
);

	import stt_pkg::*;

	stt_item_t req;
	stt_item_t q_item;
	logic      q_valid;
	logic      q_pop;
	logic      clear_done;

	always_comb begin
		req.opcode = opcode;
		req.slot   = position_hash[INDEX_BITS-1:0];
		req.verify = position_hash[63:32];
		req.depth  = search_depth;
		req.ply    = ply_from_root;
		req.alpha  = alpha_bound;
		req.beta   = beta_bound;
		req.score  = score_in;
		req.kind   = bound_kind;
		req.move   = move_in;
	end

	stt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req       (req),
		.clear_done(clear_done),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	stt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.clear_done   (clear_done),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.entry_found  (entry_found),
		.cutoff_usable(cutoff_usable),
		.score_out    (score_out),
		.move_out     (move_out),
		.store_written(store_written)
	);

endmodule
`default_nettype wire

FILE: bench/search_transposition_table_test.sv
`timescale 1ns / 100ps
module search_transposition_table_test;
	import stt_pkg::*;

	localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 333;
	localparam int PHASES = 6;

	typedef struct packed {
		logic                   op;
		logic [63:0]            hash;
		logic [DEPTH_BITS-1:0]  depth;
		logic [PLY_BITS-1:0]    ply;
		logic [SCORE_BITS-1:0]  alpha;
		logic [SCORE_BITS-1:0]  beta;
		logic [SCORE_BITS-1:0]  score;
		logic [KIND_BITS-1:0]   kind;
		logic [MOVE_BITS-1:0]   move;
	} tt_request_t;

	typedef struct packed {
		logic                   found;
		logic                   cut;
		logic [SCORE_BITS-1:0]  score;
		logic [MOVE_BITS-1:0]   move;
		logic                   written;
	} tt_answer_t;

	typedef struct {
		tt_request_t req;
		bit          typed;
		tt_answer_t  ans;
	} directed_row_t;

	localparam tt_answer_t ANSWER_NONE = '0;
	localparam tt_answer_t ANSWER_WRITTEN = '{found: 1'b0, cut: 1'b0, score: '0, move: '0,
		written: 1'b1};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [GEN_BITS-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = OP_PROBE;
	logic [63:0] position_hash = '0;
	logic [DEPTH_BITS-1:0] search_depth = '0;
	logic [PLY_BITS-1:0] ply_from_root = '0;
	logic signed [SCORE_BITS-1:0] alpha_bound = '0;
	logic signed [SCORE_BITS-1:0] beta_bound = '0;
	logic signed [SCORE_BITS-1:0] score_in = '0;
	logic [KIND_BITS-1:0] bound_kind = KIND_EXACT;
	logic [MOVE_BITS-1:0] move_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic entry_found;
	logic cutoff_usable;
	logic signed [SCORE_BITS-1:0] score_out;
	logic [MOVE_BITS-1:0] move_out;
	logic store_written;

	stt_entry_t shadow_slots [int unsigned];
	logic [GEN_BITS-1:0] current_gen = '0;
	tt_answer_t answers_due [$];
	int mismatch_count = 0;
	int beats_taken = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	search_transposition_table u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.position_hash (position_hash),
		.search_depth  (search_depth),
		.ply_from_root (ply_from_root),
		.alpha_bound   (alpha_bound),
		.beta_bound    (beta_bound),
		.score_in      (score_in),
		.bound_kind    (bound_kind),
		.move_in       (move_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.entry_found   (entry_found),
		.cutoff_usable (cutoff_usable),
		.score_out     (score_out),
		.move_out      (move_out),
		.store_written (store_written)
	);

	always #1 clk = ~clk;

	// Probe or store against the shadow table; a store that replaces updates it.
	function automatic tt_answer_t resolve_request(tt_request_t r);
		stt_entry_t e;
		tt_answer_t a;
		int unsigned slot;
		int s;
		logic [GEN_BITS-1:0] age;
		bit replace;
		a = '0;
		slot = r.hash[INDEX_BITS-1:0];
		e = shadow_slots.exists(slot) ? shadow_slots[slot] : '0;
		if (r.op == OP_PROBE) begin
			if (e.valid && e.verify == r.hash[63:32]) begin
				a.found = 1'b1;
				a.move = e.move;
				if (e.depth >= r.depth) begin
					s = $signed(e.score);
					if (s > MATE_VALUE - PLY_LIMIT)
						s = s - int'(r.ply);
					else if (s < -MATE_VALUE + PLY_LIMIT)
						s = s + int'(r.ply);
					a.score = s[SCORE_BITS-1:0];
					case (e.kind)
						KIND_EXACT: a.cut = 1'b1;
						KIND_LOWER: a.cut = (s >= $signed(r.beta));
						KIND_UPPER: a.cut = (s <= $signed(r.alpha));
						default:    a.cut = 1'b0;
					endcase
				end
			end
		end else begin
			replace = 1'b1;
			if (e.valid) begin
				age = current_gen - e.gen;
				replace = (e.verify == r.hash[63:32]) ||
					(int'(r.depth) + 2 * int'(age) >= int'(e.depth));
			end
			if (replace) begin
				s = $signed(r.score);
				if (s > MATE_VALUE - PLY_LIMIT)
					s = s + int'(r.ply);
				else if (s < -MATE_VALUE + PLY_LIMIT)
					s = s - int'(r.ply);
				e.valid = 1'b1;
				e.verify = r.hash[63:32];
				e.move = r.move;
				e.score = s[SCORE_BITS-1:0];
				e.depth = r.depth;
				e.kind = r.kind;
				e.gen = current_gen;
				shadow_slots[slot] = e;
				a.written = 1'b1;
			end
		end
		return a;
	endfunction

	function automatic tt_request_t probe_req(logic [63:0] hash, int depth, int ply,
		int alpha, int beta);
		tt_request_t r;
		r = '0;
		r.op = OP_PROBE;
		r.hash = hash;
		r.depth = depth[DEPTH_BITS-1:0];
		r.ply = ply[PLY_BITS-1:0];
		r.alpha = alpha[SCORE_BITS-1:0];
		r.beta = beta[SCORE_BITS-1:0];
		return r;
	endfunction

	function automatic tt_request_t store_req(logic [63:0] hash, int depth, int ply,
		int score, logic [KIND_BITS-1:0] kind, logic [MOVE_BITS-1:0] move);
		tt_request_t r;
		r = '0;
		r.op = OP_STORE;
		r.hash = hash;
		r.depth = depth[DEPTH_BITS-1:0];
		r.ply = ply[PLY_BITS-1:0];
		r.score = score[SCORE_BITS-1:0];
		r.kind = kind;
		r.move = move;
		return r;
	endfunction

	// Scores cluster around the mate windows and zero, with some anywhere.
	function automatic logic [SCORE_BITS-1:0] draw_score();
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = $urandom_range(28900, 32767);
			2: v = -int'($urandom_range(28900, 32768));
			default: v = int'($urandom_range(0, 200)) - 100;
		endcase
		return v[SCORE_BITS-1:0];
	endfunction

	task automatic drive_request(tt_request_t r, bit typed, tt_answer_t given);
		int gap;
		tt_answer_t predicted;
		gap = tx_calm ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= r.op;
		position_hash <= r.hash;
		search_depth <= r.depth;
		ply_from_root <= r.ply;
		alpha_bound <= r.alpha;
		beta_bound <= r.beta;
		score_in <= r.score;
		bound_kind <= r.kind;
		move_in <= r.move;
		do @(posedge clk); while (!in_ready);
		predicted = resolve_request(r);
		answers_due.push_back(typed ? given : predicted);
	endtask

	// Drain outstanding beats before touching the register.
	task automatic set_generation(logic [GEN_BITS-1:0] g);
		while (answers_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= g;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		current_gen = g;
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	initial begin : receiver
		int stall;
		tt_answer_t want;
		wait (arst_n);
		forever begin
			if (beats_taken % 64 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			// long hold-off lets the request side back up
			if (beats_taken == 150 || beats_taken == 1200)
				stall = 400;
			else
				stall = rx_calm ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			beats_taken++;
			if (answers_due.size() == 0) begin
				$display("%0t: result beat with nothing expected", $time);
				mismatch_count++;
			end else begin
				want = answers_due.pop_front();
				compare_field("entry_found", want.found, entry_found);
				compare_field("cutoff_usable", want.cut, cutoff_usable);
				compare_field("score_out", want.score, $unsigned(score_out));
				compare_field("move_out", want.move, move_out);
				compare_field("store_written", want.written, store_written);
			end
		end
	end

	initial begin : stimulus
		directed_row_t directed_rows [$];
		logic [15:0] slot_pool [8];
		logic [31:0] verify_pool [4];
		logic [GEN_BITS-1:0] gen_plan [PHASES];
		tt_request_t r;
		logic [63:0] hash_a;
		logic [63:0] hash_b;
		hash_a = 64'hA5A5_0001_0000_1234;
		hash_b = 64'h5A5A_0001_0000_1234;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		set_generation('0);

		// empty table misses, even for a zero verify
		directed_rows.push_back('{probe_req(64'h0, 0, 0, 0, 0), 1'b1, ANSWER_NONE});
		directed_rows.push_back('{probe_req('1, 255, 63, -32768, 32767), 1'b1, ANSWER_NONE});
		directed_rows.push_back('{store_req(hash_a, 10, 5, 100, KIND_EXACT, 32'hDEAD_BEEF),
			1'b1, ANSWER_WRITTEN});
		directed_rows.push_back('{probe_req(hash_a, 10, 5, 0, 0), 1'b1,
			'{found: 1'b1, cut: 1'b1, score: 16'd100, move: 32'hDEAD_BEEF, written: 1'b0}});
		// shallow hit: move only
		directed_rows.push_back('{probe_req(hash_a, 11, 5, 0, 0), 1'b1,
			'{found: 1'b1, cut: 1'b0, score: '0, move: 32'hDEAD_BEEF, written: 1'b0}});
		directed_rows.push_back('{probe_req(hash_b, 0, 0, 0, 0), 1'b1, ANSWER_NONE});
		// other position, too shallow at age zero: keep the old entry
		directed_rows.push_back('{store_req(hash_b, 9, 0, -50, KIND_LOWER, 32'h1), 1'b1,
			ANSWER_NONE});
		directed_rows.push_back('{store_req(hash_b, 10, 0, -50, KIND_LOWER, 32'h1), 1'b1,
			ANSWER_WRITTEN});
		directed_rows.push_back('{probe_req(hash_b, 0, 0, 0, -50), 1'b0, ANSWER_NONE});
		directed_rows.push_back('{probe_req(hash_b, 0, 0, 0, -49), 1'b0, ANSWER_NONE});
		// same position always replaces; winning mate wraps on store
		directed_rows.push_back('{store_req(hash_b, 0, 63, 32767, KIND_UPPER, 32'h8000_0000),
			1'b1, ANSWER_WRITTEN});
		directed_rows.push_back('{probe_req(hash_b, 0, 0, 32767, 0), 1'b0, ANSWER_NONE});
		directed_rows.push_back('{probe_req(hash_b, 0, 63, -32768, 0), 1'b0, ANSWER_NONE});
		// unused bound kind, losing mate wrap
		directed_rows.push_back('{store_req('1, 255, 63, -32768, KIND_UNUSED, '1), 1'b1,
			ANSWER_WRITTEN});
		directed_rows.push_back('{probe_req('1, 255, 0, 32767, -32768), 1'b0, ANSWER_NONE});
		directed_rows.push_back('{probe_req('1, 255, 63, 32767, -32768), 1'b0, ANSWER_NONE});
		// window edges are not mate scores; one past the edge is
		directed_rows.push_back('{store_req(64'h0, 0, 63, 28936, KIND_EXACT, 32'h0), 1'b1,
			ANSWER_WRITTEN});
		directed_rows.push_back('{probe_req(64'h0, 0, 63, 0, 0), 1'b0, ANSWER_NONE});
		directed_rows.push_back('{store_req(64'h1_0000_0000, 0, 63, -28936, KIND_LOWER,
			32'h55AA_55AA), 1'b0, ANSWER_NONE});
		directed_rows.push_back('{probe_req(64'h1_0000_0000, 0, 63, 0, -28936), 1'b0,
			ANSWER_NONE});
		directed_rows.push_back('{store_req(64'h42, 3, 1, 28937, KIND_EXACT, 32'h0BAD_F00D),
			1'b0, ANSWER_NONE});
		directed_rows.push_back('{probe_req(64'h42, 3, 63, 0, 0), 1'b0, ANSWER_NONE});
		directed_rows.push_back('{probe_req(64'h42, 0, 0, 0, 0), 1'b0, ANSWER_NONE});

		foreach (directed_rows[i])
			drive_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].ans);
		in_valid <= 1'b0;

		foreach (slot_pool[i])
			slot_pool[i] = 16'($urandom_range(0, 16'hFFFF));
		foreach (verify_pool[i])
			verify_pool[i] = $urandom;
		gen_plan = '{6'd63, 6'd1, 6'd0, GEN_BITS'($urandom), 6'd32, GEN_BITS'($urandom)};

		for (int p = 0; p < PHASES; p++) begin
			set_generation(gen_plan[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 64 == 0)
					tx_calm = ($urandom_range(0, 3) == 0);
				r.op = $urandom_range(0, 1) ? OP_STORE : OP_PROBE;
				// mostly a few shared slots so stores and probes meet
				if ($urandom_range(0, 4) == 0)
					r.hash = {$urandom, $urandom};
				else
					r.hash = {verify_pool[$urandom_range(0, 3)], 16'($urandom),
						slot_pool[$urandom_range(0, 7)]};
				r.depth = DEPTH_BITS'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 24));
				r.ply = PLY_BITS'($urandom_range(0, 63));
				r.alpha = draw_score();
				r.beta = draw_score();
				r.score = draw_score();
				r.kind = KIND_BITS'($urandom_range(0, 3));
				r.move = $urandom;
				drive_request(r, 1'b0, ANSWER_NONE);
			end
			in_valid <= 1'b0;
		end

		while (answers_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, answers_due.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
